>>> hw/rtl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared constants, codes and types of the FIR convolver with limiter.
// ----------------------------------------------------------------------------
package fcl_pkg;

	// tap store depth, must be a power of two (delay line pointer wraps)
	localparam int MAX_TAPS   = 4096;
	localparam int SAMPLE_W   = 16;
	localparam int ADDR_W     = $clog2(MAX_TAPS);
	localparam int TAPS_W     = ADDR_W + 1;
	// products plus growth over all taps, plus sign
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int ACC_W      = PROD_W + ADDR_W + 1;

	// apb register port
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;

	// register indexes (word address)
	localparam logic REG_TAP_COUNT = 1'b0;

	localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = TAPS_W'(MAX_TAPS);

	// input command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} res_t;

endpackage

>>> hw/rtl/fcl_if.sv
// ----------------------------------------------------------------------------
// fcl_if
// Valid/ready channels of the FIR convolver: command input and result output.
// ----------------------------------------------------------------------------
interface fcl_in_if;
	import fcl_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [ADDR_W-1:0]          tap_index;
	logic signed [SAMPLE_W-1:0] value;

	modport source (output valid, command, tap_index, value, input ready);
	modport sink   (input valid, command, tap_index, value, output ready);
endinterface

interface fcl_out_if;
	import fcl_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       clipped;

	modport source (output valid, out_sample, clipped, input ready);
	modport sink   (input valid, out_sample, clipped, output ready);
endinterface

>>> hw/rtl/fcl_ram.sv
// ----------------------------------------------------------------------------
// fcl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fcl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hw/rtl/fcl_limiter.sv
// ----------------------------------------------------------------------------
// fcl_limiter
// Rounds the accumulator to Q1.15 (half up) and clamps it to the sample range.
// ----------------------------------------------------------------------------
module fcl_limiter (
	input  logic signed [fcl_pkg::ACC_W-1:0] acc,
	output fcl_pkg::res_t                    res
);
	import fcl_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (SAMPLE_W - 2);
	localparam logic signed [ACC_W-1:0] LIM_HI =
		{{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] LIM_LO =
		{{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

	logic signed [ACC_W-1:0] rounded;
	logic signed [ACC_W-1:0] shifted;

	always_comb begin
		rounded = acc + ROUND_BIAS;
		shifted = rounded >>> (SAMPLE_W - 1);
		if (shifted > LIM_HI) begin
			res.sample  = LIM_HI[SAMPLE_W-1:0];
			res.clipped = 1'b1;
		end else if (shifted < LIM_LO) begin
			res.sample  = LIM_LO[SAMPLE_W-1:0];
			res.clipped = 1'b1;
		end else begin
			res.sample  = shifted[SAMPLE_W-1:0];
			res.clipped = 1'b0;
		end
	end
endmodule

>>> hw/rtl/fcl_engine.sv
// ----------------------------------------------------------------------------
// fcl_engine
// Coefficient and delay line RAMs, tap sequencer, multiply-accumulate pipe
// and the output register.
// ----------------------------------------------------------------------------
module fcl_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fcl_pkg::TAPS_W-1:0]  tap_count,
	fcl_in_if.sink                      in_ch,
	fcl_out_if.source                   out_ch
);
	import fcl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t                  state_q;
	logic [ADDR_W-1:0]       newest_q;
	logic [TAPS_W-1:0]       fill_q;
	logic [TAPS_W-1:0]       taps_q;
	logic [ADDR_W-1:0]       j_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    out_valid_q;
	res_t                    out_q;

	logic                    valid_s1;
	logic                    zero_s1;
	logic                    valid_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic                    take;
	logic                    is_sample;
	logic [ADDR_W-1:0]       newest_inc;
	logic [TAPS_W-1:0]       tap_sat;
	logic                    issue;
	logic                    out_free;
	logic                    flush_done;
	logic [SAMPLE_W-1:0]     coef_rd;
	logic [SAMPLE_W-1:0]     delay_rd;
	res_t                    lim_res;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign take        = in_ch.valid && in_ch.ready;
	assign is_sample   = (in_ch.command == CMD_SAMPLE);
	assign newest_inc  = newest_q + 1'b1;
	assign tap_sat     = (tap_count > TAPS_W'(MAX_TAPS)) ? TAPS_W'(MAX_TAPS) : tap_count;
	assign issue       = (state_q == ST_RUN);
	assign out_free    = !out_valid_q || out_ch.ready;
	// mac pipe drained and the output slot free
	assign flush_done  = (state_q == ST_FLUSH) && !valid_s1 && !valid_s2 && out_free;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_sample = out_q.sample;
	assign out_ch.clipped    = out_q.clipped;

	fcl_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (take && !is_sample),
		.waddr (in_ch.tap_index),
		.wdata (in_ch.value),
		.re    (issue),
		.raddr (j_q),
		.rdata (coef_rd)
	);

	fcl_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_delay_ram (
		.clk   (clk),
		.we    (take && is_sample),
		.waddr (newest_inc),
		.wdata (in_ch.value),
		.re    (issue),
		.raddr (newest_q - j_q),
		.rdata (delay_rd)
	);

	fcl_limiter u_limiter (
		.acc (acc_q),
		.res (lim_res)
	);

	// read data stage and product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		// delay line entries not yet written since reset read as zero
		zero_s1 <= ({1'b0, j_q} >= fill_q);
		if (zero_s1) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= $signed(coef_rd) * $signed(delay_rd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			newest_q    <= '0;
			fill_q      <= '0;
			taps_q      <= '0;
			j_q         <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (flush_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			case (state_q)
				ST_IDLE: begin
					if (take && is_sample) begin
						newest_q <= newest_inc;
						if (fill_q != TAPS_W'(MAX_TAPS)) begin
							fill_q <= fill_q + 1'b1;
						end
						taps_q <= tap_sat;
						j_q    <= '0;
						acc_q  <= '0;
						state_q <= (tap_sat == '0) ? ST_FLUSH : ST_RUN;
					end
				end
				ST_RUN: begin
					j_q <= j_q + 1'b1;
					if ({1'b0, j_q} == taps_q - 1'b1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (flush_done) begin
						out_q   <= lim_res;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> hw/rtl/fir_convolver_with_limiter_top.sv
// ----------------------------------------------------------------------------
// fir_convolver_with_limiter_top
// Direct-form FIR convolver in Q1.15 with a saturating output limiter.
// ----------------------------------------------------------------------------
// A coefficient load gives no result; loads may follow each other in every
// cycle. After a sample item the block takes no next item until the tap walk
// is over and the read data and product stages have drained (a count above
// 4096 walks 4096 taps, a count of zero walks none), since one multiplier
// walks the taps one per cycle, reading one word from the
// coefficient RAM and one from the delay line RAM. The result waits in an
// output register, so the next item is taken while it is still pending; a walk
// that ends while the previous result is still waiting holds until that result
// has been taken. The delay line needs no clearing after reset: a fill count
// makes unwritten entries read as zero. tap_count sits at byte address 0 of
// the APB port.
module fir_convolver_with_limiter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	fcl_in_if.sink                            in_ch,
	fcl_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fcl_pkg::PADDR_W-1:0]       paddr,
	input  logic [fcl_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [fcl_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import fcl_pkg::*;

	logic [TAPS_W-1:0] tap_count_q;
	logic              reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_TAP_COUNT);
	assign prdata  = reg_hit ? {{(APB_DATA_W-TAPS_W){1'b0}}, tap_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			tap_count_q <= pwdata[TAPS_W-1:0];
		end
	end

	fcl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap_count (tap_count_q),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// a sample transfer starts the tap walk, so no item follows at once
	a_sample_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.command == CMD_SAMPLE) |=> !in_ch.ready)
		else $error("input ready right after a sample transfer");

	// coefficient loads never stall the input
	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.command == CMD_LOAD) |=> in_ch.ready)
		else $error("input stalled after a coefficient load");

	// a clamped result sits exactly on a limit
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.clipped) |->
			(out_ch.out_sample == {1'b0, {(SAMPLE_W-1){1'b1}}} ||
			 out_ch.out_sample == {1'b1, {(SAMPLE_W-1){1'b0}}}))
		else $error("clipped result not at a limit");

	// a new result only appears while the sequencer is idle again
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> in_ch.ready)
		else $error("result raised while a tap walk is running");
endmodule
